FILE: rtl/ucbs_pkg.sv
// Shared types and constants for the uniform cubic B-spline sampler.
// Used by ucbs_ctrl, ucbs_datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps

package ucbs_pkg;

  // sample count register and the powers of the segment sample count
  localparam int SC_W  = 6;
  localparam int S2_W  = 12;
  localparam int S3_W  = 18;
  // basis numerators and the denominator 6*s^3 both fit in this width
  localparam int N_W   = 21;

  localparam logic [SC_W-1:0] SC_RESET = 6'd10;

  // multiply-accumulate sweep: four products plus one drain step
  localparam int MAC_STEPS = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_CUBE,
    ST_LOAD,
    ST_DIVIDE,
    ST_MAC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       take;
    logic       square;
    logic       cube;
    logic       load;
    logic       div_step;
    logic       mac_step;
    logic [2:0] mac_idx;
    logic       emit;
    logic       advance;
  } cmd_t;

  typedef struct packed {
    logic seg_start;
    logic last_j;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/uniform_cubic_bspline_sampler.sv
// Top level of the uniform cubic B-spline sampler.
// Depends on ucbs_pkg, ucbs_ctrl, ucbs_datapath (and ucbs_div_lane below it).
//
// Control points enter on the input channel (in_valid / in_stall), one
// transaction per point; first_point starts a new path and clears the window.
// From the fourth point of a path on, each point produces s+1 curve samples
// on the output channel (out_valid / out_stall), the last one flagged by
// last_sample; s is sample_count, with zero taken as one and values above
// MAX_SAMPLES taken as MAX_SAMPLES. A point that completes no segment leaves
// the sequencer idle. For a segment point the sequencer squares and cubes s,
// then for each sample loads the four weight dividers, runs FRAC_BITS
// divider steps, five multiply-accumulate steps and one load of the output
// register. The output register lets the next point in while the last sample
// waits; a stalled output holds the sequencer at the sample after it.
// The user must write sample_count through cfg_wr_en / cfg_wr_data only
// while idle; the block itself does not enforce this.
// Synchronous reset sets sample_count to 10, clears the window and path
// length and drops out_valid.
`timescale 1ns / 1ps

module uniform_cubic_bspline_sampler import ucbs_pkg::*; #(
  parameter int MAX_SAMPLES = 63,
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [SC_W-1:0]               cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic                          first_point,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] smooth_x,
  output logic signed [COORD_WIDTH-1:0] smooth_y,
  output logic                          last_sample
);

  cmd_t    cmd;
  status_t stat;

  ucbs_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  ucbs_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .point_x     (point_x),
    .point_y     (point_y),
    .first_point (first_point),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .smooth_x    (smooth_x),
    .smooth_y    (smooth_y),
    .last_sample (last_sample),
    .cmd         (cmd),
    .stat        (stat)
  );

  // a sample is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("sample loaded over a waiting result");

  // a point that completes a segment closes the input
  a_seg_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && stat.seg_start) |=> in_stall)
    else $error("input open during segment setup");

  // a point that completes no segment leaves the input open
  a_short_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !stat.seg_start) |=> !in_stall)
    else $error("input closed after a point with no segment");

  // the final sample of a segment returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && stat.last_j) |=> (!in_stall && out_valid && last_sample))
    else $error("final sample did not release the input");

endmodule

FILE: rtl/ucbs_div_lane.sv
// Restoring divider lane: one quotient bit per step.
// Produces one basis weight; quotient is known to fit in Q_W bits.
// No package dependencies.
`timescale 1ns / 1ps

module ucbs_div_lane #(
  parameter int DEN_W = 21,
  parameter int Q_W   = 16
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic                   step,
  input  logic [DEN_W+Q_W-1:0]   num,
  input  logic [DEN_W-1:0]       den,
  output logic [Q_W-1:0]         quo
);

  logic [DEN_W-1:0] rem;
  logic [Q_W-1:0]   low;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem, low[Q_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};

  // low holds the unused numerator bits and collects the quotient behind them
  always_ff @(posedge clk) begin
    if (load) begin
      rem <= num[DEN_W+Q_W-1:Q_W];
      low <= num[Q_W-1:0];
    end else if (step) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low <= {low[Q_W-2:0], ge};
    end
  end

  assign quo = low;

endmodule

FILE: rtl/ucbs_ctrl.sv
// Sequencer for the B-spline sampler: setup, divide, multiply-accumulate, emit.
// Depends on ucbs_pkg (state_t, cmd_t, status_t).
`timescale 1ns / 1ps

module ucbs_ctrl import ucbs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output cmd_t    cmd,
  input  status_t stat
);

  localparam int CNT_W = $clog2(FRAC_BITS);
  localparam logic [CNT_W-1:0] DIV_END = CNT_W'(FRAC_BITS - 1);
  localparam logic [CNT_W-1:0] MAC_END = CNT_W'(MAC_STEPS - 1);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (in_valid && stat.seg_start) begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: state_next = ST_CUBE;
      ST_CUBE:   state_next = ST_LOAD;
      ST_LOAD: begin
        state_next = ST_DIVIDE;
        cnt_next   = '0;
      end
      ST_DIVIDE: begin
        if (cnt == DIV_END) begin
          state_next = ST_MAC;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_MAC: begin
        if (cnt == MAC_END) begin
          state_next = ST_EMIT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          state_next = stat.last_j ? ST_IDLE : ST_LOAD;
        end
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      ST_SQUARE: cmd.square   = 1'b1;
      ST_CUBE:   cmd.cube     = 1'b1;
      ST_LOAD:   cmd.load     = 1'b1;
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_MAC: begin
        cmd.mac_step = 1'b1;
        cmd.mac_idx  = cnt[2:0];
      end
      ST_EMIT: begin
        cmd.emit    = stat.out_free;
        cmd.advance = stat.out_free && !stat.last_j;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

FILE: rtl/ucbs_datapath.sv
// Datapath of the B-spline sampler: point window, basis numerators,
// four divider lanes, multiply-accumulate, rounding and the output register.
// Depends on ucbs_pkg and ucbs_div_lane.
`timescale 1ns / 1ps

module ucbs_datapath import ucbs_pkg::*; #(
  parameter int MAX_SAMPLES = 63,
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [SC_W-1:0]               cfg_wr_data,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic                          first_point,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] smooth_x,
  output logic signed [COORD_WIDTH-1:0] smooth_y,
  output logic                          last_sample,
  input  cmd_t                          cmd,
  output status_t                       stat
);

  localparam int NUM_W  = N_W + FRAC_BITS;
  localparam int PROD_W = COORD_WIDTH + FRAC_BITS + 1;
  localparam int ACC_W  = (COORD_WIDTH + FRAC_BITS + 3 > 64) ? 64
                                                             : COORD_WIDTH + FRAC_BITS + 3;
  localparam int EXT_W  = PROD_W + ACC_W;
  localparam logic [SC_W-1:0] S_MAX = SC_W'(MAX_SAMPLES);
  localparam logic [ACC_W-1:0] HALF =
    {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] MAXV =
    {{(ACC_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] MINV =
    {{(ACC_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  logic [SC_W-1:0]               sample_count;
  logic [SC_W-1:0]               s_eff;
  logic [1:0]                    points_seen;
  logic signed [COORD_WIDTH-1:0] window_x [3];
  logic signed [COORD_WIDTH-1:0] window_y [3];
  logic signed [COORD_WIDTH-1:0] seg_x [4];
  logic signed [COORD_WIDTH-1:0] seg_y [4];

  logic [SC_W-1:0] s;
  logic [S2_W-1:0] s2;
  logic [S3_W-1:0] s3;
  logic [N_W-1:0]  den;
  logic [SC_W-1:0] j;
  logic [S2_W-1:0] j2;
  logic [S3_W-1:0] j3;
  logic [S2_W-1:0] js;
  logic [S3_W-1:0] js2;
  logic [S3_W-1:0] j2s;

  logic [N_W-1:0]       s3n, j3n, js2n, j2sn;
  logic [N_W-1:0]       n [4];
  logic [NUM_W-1:0]     num [4];
  logic [FRAC_BITS-1:0] weight [4];

  logic signed [PROD_W-1:0] prod_full_x, prod_full_y;
  logic signed [EXT_W-1:0]  prod_ext_x, prod_ext_y;
  logic signed [ACC_W-1:0]  prod_x, prod_y;
  logic signed [ACC_W-1:0]  acc_x, acc_y;
  logic [S3_W-1:0]          tj, tj2;

  function automatic logic [COORD_WIDTH-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] sh;
    logic [COORD_WIDTH-1:0]  res;
    sum = a + HALF;
    sh  = sum >>> FRAC_BITS;
    if (sh > MAXV) begin
      res = MAXV[COORD_WIDTH-1:0];
    end else if (sh < MINV) begin
      res = MINV[COORD_WIDTH-1:0];
    end else begin
      res = sh[COORD_WIDTH-1:0];
    end
    return res;
  endfunction

  // zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (sample_count == '0) begin
      s_eff = SC_W'(1);
    end else if (sample_count > S_MAX) begin
      s_eff = S_MAX;
    end else begin
      s_eff = sample_count;
    end
  end

  assign stat.seg_start = !first_point && (points_seen == 2'd3);
  assign stat.last_j    = (j == s);
  assign stat.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= SC_RESET;
    end else if (cfg_wr_en) begin
      sample_count <= cfg_wr_data;
    end
  end

  // window and path length
  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= '0;
      for (int k = 0; k < 3; k++) begin
        window_x[k] <= '0;
        window_y[k] <= '0;
      end
    end else if (cmd.take) begin
      if (first_point) begin
        points_seen <= 2'd1;
        window_x[0] <= '0;
        window_y[0] <= '0;
        window_x[1] <= '0;
        window_y[1] <= '0;
      end else begin
        if (points_seen != 2'd3) begin
          points_seen <= points_seen + 2'd1;
        end
        window_x[0] <= window_x[1];
        window_y[0] <= window_y[1];
        window_x[1] <= window_x[2];
        window_y[1] <= window_y[2];
      end
      window_x[2] <= point_x;
      window_y[2] <= point_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      for (int k = 0; k < 3; k++) begin
        seg_x[k] <= window_x[k];
        seg_y[k] <= window_y[k];
      end
      seg_x[3] <= point_x;
      seg_y[3] <= point_y;
      s        <= s_eff;
    end
  end

  // powers of s, then running powers of j by forward differences
  assign tj  = S3_W'(j);
  assign tj2 = S3_W'(j2);

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      s2 <= S2_W'(s) * S2_W'(s);
    end
    if (cmd.cube) begin
      s3  <= S3_W'(s2) * S3_W'(s);
      j   <= '0;
      j2  <= '0;
      j3  <= '0;
      js  <= '0;
      js2 <= '0;
      j2s <= '0;
    end
    if (cmd.load) begin
      den <= (s3n << 2) + (s3n << 1);
    end
    if (cmd.advance) begin
      j   <= j + 1'b1;
      j2  <= j2 + (S2_W'(j) << 1) + 1'b1;
      j3  <= j3 + (tj2 << 1) + tj2 + (tj << 1) + tj + 1'b1;
      js  <= js + S2_W'(s);
      js2 <= js2 + S3_W'(s2);
      j2s <= j2s + (S3_W'(js) << 1) + S3_W'(s);
    end
  end

  // basis numerators, modulo 2^N_W: every final value fits
  assign s3n  = N_W'(s3);
  assign j3n  = N_W'(j3);
  assign js2n = N_W'(js2);
  assign j2sn = N_W'(j2s);

  always_comb begin
    n[0] = s3n - ((js2n << 1) + js2n) + ((j2sn << 1) + j2sn) - j3n;
    n[1] = (s3n << 2) + ((j3n << 1) + j3n) - ((j2sn << 2) + (j2sn << 1));
    n[2] = s3n + ((js2n << 1) + js2n) + ((j2sn << 1) + j2sn) - ((j3n << 1) + j3n);
    n[3] = j3n;
    for (int k = 0; k < 4; k++) begin
      num[k] = {n[k], {FRAC_BITS{1'b0}}} + NUM_W'((s3n << 1) + s3n);
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    ucbs_div_lane #(
      .DEN_W (N_W),
      .Q_W   (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .load (cmd.load),
      .step (cmd.div_step),
      .num  (num[k]),
      .den  (den),
      .quo  (weight[k])
    );
  end

  // one product per cycle per axis; each product is registered before it is accumulated
  assign prod_full_x = PROD_W'($signed({1'b0, weight[cmd.mac_idx[1:0]]}))
                     * PROD_W'(seg_x[cmd.mac_idx[1:0]]);
  assign prod_full_y = PROD_W'($signed({1'b0, weight[cmd.mac_idx[1:0]]}))
                     * PROD_W'(seg_y[cmd.mac_idx[1:0]]);
  assign prod_ext_x  = EXT_W'(prod_full_x);
  assign prod_ext_y  = EXT_W'(prod_full_y);

  always_ff @(posedge clk) begin
    if (cmd.mac_step) begin
      if (cmd.mac_idx != 3'(MAC_STEPS - 1)) begin
        prod_x <= prod_ext_x[ACC_W-1:0];
        prod_y <= prod_ext_y[ACC_W-1:0];
      end
      if (cmd.mac_idx == 3'd0) begin
        acc_x <= '0;
        acc_y <= '0;
      end else begin
        acc_x <= acc_x + prod_x;
        acc_y <= acc_y + prod_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      smooth_x    <= round_sat(acc_x);
      smooth_y    <= round_sat(acc_y);
      last_sample <= (j == s);
    end
  end

endmodule
